### hdl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
// Depends on nothing; the using module must have signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/psr_pkg.sv
// Shared types and constants for the palette sprite row renderer.
// Depends on nothing; used by psr_palette, psr_position and the top level.
`default_nettype none

package psr_pkg;

   localparam int PAL_ENTRIES = 256;
   localparam int PAL_AW      = $clog2(PAL_ENTRIES);
   localparam int MAX_WIDTH   = 240;
   localparam int MAX_HEIGHT  = 135;

   localparam logic FUNC_PALETTE = 1'b0;
   localparam logic FUNC_PIXEL   = 1'b1;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_TRANSPARENT   = 3'd4,
      CSR_FLIP          = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0]         sprite_width;
      logic [7:0]         sprite_height;
      logic [7:0]         transparent_index;
      logic               flip_horizontal;
   } cfg_type;

   typedef struct packed {
      logic signed [16:0] screen_x;
      logic signed [16:0] screen_y;
   } pos_type;

endpackage

`default_nettype wire

### hdl/psr_req_if.sv
// Request and response channel interfaces of the palette sprite row renderer.
// Depends on nothing; one word per valid and ready handshake.
`default_nettype none

interface psr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  palette_slot;
   logic [15:0] palette_color;
   logic [7:0]  pixel_index;

   modport source (output valid, func, palette_slot, palette_color, pixel_index,
                   input ready);
   modport sink   (input valid, func, palette_slot, palette_color, pixel_index,
                   output ready);
endinterface

interface psr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] screen_x;
   logic signed [16:0] screen_y;
   logic [15:0]        color;

   modport source (output valid, screen_x, screen_y, color, input ready);
   modport sink   (input valid, screen_x, screen_y, color, output ready);
endinterface

`default_nettype wire

### hdl/psr_palette.sv
// Palette store: one write and one registered read per cycle, with per-entry
// valid bits so that unwritten entries read as zero. Depends on psr_pkg.
`default_nettype none

module psr_palette (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [7:0]                 wr_slot,
   input  wire logic [15:0]                wr_color,
   input  wire logic                       rd_en,
   input  wire logic [7:0]                 rd_slot,
   output logic      [15:0]                rd_color
);

   logic [15:0]                        mem [psr_pkg::PAL_ENTRIES];
   logic [psr_pkg::PAL_ENTRIES-1:0]    valid_ff;
   logic [15:0]                        rdata_ff;
   logic                               rvalid_ff;
   logic                               wr_hit;
   logic                               rd_hit;

   assign wr_hit = wr_en && ({1'b0, wr_slot} < 9'(psr_pkg::PAL_ENTRIES));
   assign rd_hit = {1'b0, rd_slot} < 9'(psr_pkg::PAL_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_slot[psr_pkg::PAL_AW-1:0]] <= wr_color;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_slot[psr_pkg::PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_hit) begin
            valid_ff[wr_slot[psr_pkg::PAL_AW-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= rd_hit && valid_ff[rd_slot[psr_pkg::PAL_AW-1:0]];
         end
      end
   end

   // out-of-range and never-written entries read as zero
   assign rd_color = rvalid_ff ? rdata_ff : 16'd0;

endmodule

`default_nettype wire

### hdl/psr_position.sv
// Column and row counters with the screen coordinate of the current pixel.
// Depends on psr_pkg.
`default_nettype none

module psr_position (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire psr_pkg::cfg_type cfg,
   input  wire logic             advance,
   output psr_pkg::pos_type      pos
);

   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] w, h;
   logic [7:0] col, row, disp;
   logic [8:0] row_wrap, col_inc, row_inc;

   always_comb begin
      if (cfg.sprite_width == 8'd0) begin
         w = 8'd1;
      end else if (int'(cfg.sprite_width) > psr_pkg::MAX_WIDTH) begin
         w = 8'(psr_pkg::MAX_WIDTH);
      end else begin
         w = cfg.sprite_width;
      end
      if (cfg.sprite_height == 8'd0) begin
         h = 8'd1;
      end else if (int'(cfg.sprite_height) > psr_pkg::MAX_HEIGHT) begin
         h = 8'(psr_pkg::MAX_HEIGHT);
      end else begin
         h = cfg.sprite_height;
      end

      // geometry may have shrunk mid-frame: start a fresh row or frame
      col      = col_ff;
      row_wrap = {1'b0, row_ff};
      if (col_ff >= w) begin
         col      = 8'd0;
         row_wrap = {1'b0, row_ff} + 9'd1;
      end
      row = (row_wrap >= {1'b0, h}) ? 8'd0 : row_wrap[7:0];

      disp = cfg.flip_horizontal ? (w - 8'd1 - col) : col;

      pos.screen_x = $signed({cfg.origin_x[15], cfg.origin_x}) + $signed({9'd0, disp});
      pos.screen_y = $signed({cfg.origin_y[15], cfg.origin_y}) + $signed({9'd0, row});

      col_inc = {1'b0, col} + 9'd1;
      row_inc = {1'b0, row} + 9'd1;
      col_in  = col_inc[7:0];
      row_in  = row;
      if (col_inc >= {1'b0, w}) begin
         col_in = 8'd0;
         row_in = (row_inc >= {1'b0, h}) ? 8'd0 : row_inc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         row_ff <= 8'd0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### hdl/palette_sprite_row_render_core.sv
// Palette sprite row renderer: top level with configuration registers,
// palette read stage and output register. Depends on psr_pkg, the channel
// interfaces, psr_palette, psr_position and assert_macros.svh.
//
// Usage: req_port carries one word per handshake. func low writes
// palette_color into palette entry palette_slot and gives no response.
// func high delivers the next sprite pixel index in source row order; an
// opaque index gives one rsp_port word with screen_x, screen_y and color,
// a transparent index gives none but still advances the position.
// Configuration is written on csr_we with csr_index and csr_wdata; the user
// writes it only while no word is in flight, as the block does not enforce it.
// An opaque pixel goes through the read stage and the output register to
// rsp_port. Throughput: one word per cycle unless stalled, set by the
// single palette read port and the one add per coordinate ahead of the
// read stage. When the receiver stalls, words are still taken until an
// opaque pixel waits in the read stage; then req_port.ready drops until
// rsp_port.ready returns and the output register can move on.
// Reset clears the counters, the palette valid bits (every entry reads
// as zero) and the configuration to origin 0, 240 by 135, key 0, no flip.
`default_nettype none
`include "assert_macros.svh"

module palette_sprite_row_render_core (
   input  wire logic        clock,
   input  wire logic        reset,
   psr_req_if.sink          req_port,
   psr_rsp_if.source        rsp_port,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   psr_pkg::cfg_type cfg_ff;
   psr_pkg::pos_type pos;
   psr_pkg::pos_type s1_pos_ff;
   logic             s1_valid_ff;
   logic             out_valid_ff;
   logic signed [16:0] out_x_ff;
   logic signed [16:0] out_y_ff;
   logic [15:0]      out_color_ff;
   logic [15:0]      rd_color;
   logic             accept;
   logic             take_pixel;
   logic             emit;
   logic             out_free;
   logic             s1_move;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x          <= 16'sd0;
         cfg_ff.origin_y          <= 16'sd0;
         cfg_ff.sprite_width      <= 8'd240;
         cfg_ff.sprite_height     <= 8'd135;
         cfg_ff.transparent_index <= 8'd0;
         cfg_ff.flip_horizontal   <= 1'b0;
      end else if (csr_we) begin
         unique case (psr_pkg::csr_index_type'(csr_index))
            psr_pkg::CSR_ORIGIN_X:      cfg_ff.origin_x          <= csr_wdata;
            psr_pkg::CSR_ORIGIN_Y:      cfg_ff.origin_y          <= csr_wdata;
            psr_pkg::CSR_SPRITE_WIDTH:  cfg_ff.sprite_width      <= csr_wdata[7:0];
            psr_pkg::CSR_SPRITE_HEIGHT: cfg_ff.sprite_height     <= csr_wdata[7:0];
            psr_pkg::CSR_TRANSPARENT:   cfg_ff.transparent_index <= csr_wdata[7:0];
            psr_pkg::CSR_FLIP:          cfg_ff.flip_horizontal   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;
   assign take_pixel     = accept && (req_port.func == psr_pkg::FUNC_PIXEL);
   assign emit           = take_pixel && (req_port.pixel_index != cfg_ff.transparent_index);

   psr_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_port.func == psr_pkg::FUNC_PALETTE)),
      .wr_slot  (req_port.palette_slot),
      .wr_color (req_port.palette_color),
      .rd_en    (take_pixel),
      .rd_slot  (req_port.pixel_index),
      .rd_color (rd_color)
   );

   psr_position u_position (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (take_pixel),
      .pos     (pos)
   );

   // read stage: holds while the output register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= emit;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel) begin
         s1_pos_ff <= pos;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_x_ff     <= s1_pos_ff.screen_x;
         out_y_ff     <= s1_pos_ff.screen_y;
         out_color_ff <= rd_color;
      end
   end

   assign rsp_port.valid    = out_valid_ff;
   assign rsp_port.screen_x = out_x_ff;
   assign rsp_port.screen_y = out_y_ff;
   assign rsp_port.color    = out_color_ff;

   `ASSERT_SAME(a_full_blocks_req, s1_valid_ff && out_valid_ff && !rsp_port.ready, !req_port.ready)
   `ASSERT_NEXT(a_accept_loads_s1, accept, s1_valid_ff == $past(emit))
   `ASSERT_NEXT(a_s1_drains, s1_valid_ff && !out_valid_ff, out_valid_ff)

endmodule

`default_nettype wire
